/* sv/frequency_table_max_query_defines.svh */
// Assertion macros for the checker file.
`ifndef FREQUENCY_TABLE_MAX_QUERY_DEFINES_SVH
`define FREQUENCY_TABLE_MAX_QUERY_DEFINES_SVH

// Same-cycle implication, off while reset is low.
`define FTMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ftmq: check failed");

// Next-cycle implication, off while reset is low.
`define FTMQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ftmq: check failed");

// State in the cycle after reset is seen low.
`define FTMQ_ASSERT_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("ftmq: reset check failed");

`endif

/* sv/ftmq_pkg.sv */
package ftmq_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int COUNT_WIDTH = 48;

    localparam int REQ_W     = 2;
    localparam int KEY_W     = 12;
    localparam int AMT_W     = 32;
    localparam int ADDR_W    = $clog2(TABLE_DEPTH);
    localparam int DEPTH_W   = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_EXT_W = (KEY_W > DEPTH_W) ? KEY_W : DEPTH_W;
    localparam int SUM_W     = ((COUNT_WIDTH > AMT_W) ? COUNT_WIDTH : AMT_W) + 1;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req;

    typedef struct packed {
        logic cnt_clr;
        logic cnt_inc;
        logic scan_rd;
        logic upd_wr;
        logic clr_wr;
        logic best_clr;
        logic in_load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic cnt_last;
    } t_sts;

endpackage

/* sv/ftmq_req_if.sv */
interface ftmq_req_if;
    import ftmq_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;

    modport source (output valid, output req_type, output key, output amount, input ready);
    modport sink   (input valid, input req_type, input key, input amount, output ready);
endinterface

/* sv/ftmq_rsp_if.sv */
interface ftmq_rsp_if;
    import ftmq_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] top_key;
    logic             top_valid;

    modport source (output valid, output top_key, output top_valid, input ready);
    modport sink   (input valid, input top_key, input top_valid, output ready);
endinterface

/* sv/ftmq_ram.sv */
module ftmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/ftmq_ctrl.sv */
module ftmq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  ftmq_pkg::t_sts i_sts,
    output ftmq_pkg::t_cmd o_cmd
);
    import ftmq_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_UPD_RD = 7'b0000100,
        S_UPD_WR = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_DRAIN  = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovld, n_ovld;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        n_ovld  = r_ovld && !i_out_ready;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (i_sts.cnt_last) begin
                    cmd.cnt_clr = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_IDLE: begin
                cmd.cnt_clr = 1'b1;
                if (i_in_valid) begin
                    cmd.in_load = 1'b1;
                    if (i_sts.is_query) begin
                        cmd.best_clr = 1'b1;
                        n_state      = S_SCAN;
                    end else begin
                        n_state = S_UPD_RD;
                    end
                end
            end
            S_UPD_RD: begin
                n_state = S_UPD_WR;
            end
            S_UPD_WR: begin
                cmd.upd_wr = 1'b1;
                n_state    = S_IDLE;
            end
            S_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (i_sts.cnt_last) begin
                    cmd.cnt_clr = 1'b1;
                    n_state     = S_DRAIN;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovld || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_ovld       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_cmd       = cmd;
endmodule

/* sv/ftmq_dp.sv */
module ftmq_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ftmq_pkg::REQ_W-1:0]  i_req_type,
    input  logic [ftmq_pkg::KEY_W-1:0]  i_key,
    input  logic [ftmq_pkg::AMT_W-1:0]  i_amount,
    input  ftmq_pkg::t_cmd              i_cmd,
    output ftmq_pkg::t_sts              o_sts,
    output logic [ftmq_pkg::KEY_W-1:0]  o_top_key,
    output logic                        o_top_valid
);
    import ftmq_pkg::*;

    logic [ADDR_W-1:0]      r_addr;
    logic                   r_key_ok;
    logic                   r_is_add;
    logic [AMT_W-1:0]       r_amt;
    logic [ADDR_W-1:0]      r_cnt;
    logic                   r_cmp_vld;
    logic [ADDR_W-1:0]      r_cmp_key;
    logic [COUNT_WIDTH-1:0] r_best;
    logic [ADDR_W-1:0]      r_best_key;
    logic                   r_found;
    logic [KEY_W-1:0]       r_out_key;
    logic                   r_out_vld;

    logic [KEY_EXT_W-1:0]   key_ext;
    logic [KEY_EXT_W-1:0]   best_ext;
    logic [COUNT_WIDTH-1:0] rdata;
    logic [COUNT_WIDTH-1:0] upd_val;
    logic [SUM_W-1:0]       cur_x;
    logic [SUM_W-1:0]       amt_x;
    logic [SUM_W-1:0]       sum;
    logic [SUM_W-1:0]       diff;
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [COUNT_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]      raddr;
    logic                   take;

    assign key_ext = KEY_EXT_W'(i_key);

    always_comb begin
        cur_x = SUM_W'(rdata);
        amt_x = SUM_W'(r_amt);
        sum   = cur_x + amt_x;
        diff  = cur_x - amt_x;
        if (r_is_add) begin
            upd_val = (sum >= SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
        end else begin
            upd_val = (amt_x >= cur_x) ? '0 : diff[COUNT_WIDTH-1:0];
        end
    end

    assign we    = i_cmd.clr_wr || (i_cmd.upd_wr && r_key_ok);
    assign waddr = i_cmd.clr_wr ? r_cnt : r_addr;
    assign wdata = i_cmd.clr_wr ? '0 : upd_val;
    assign raddr = i_cmd.scan_rd ? r_cnt : r_addr;

    ftmq_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // ties go to the later (larger) key
    assign take = r_cmp_vld && (rdata != '0) && (rdata >= r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_cmp_vld <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_addr   <= key_ext[ADDR_W-1:0];
            r_key_ok <= key_ext < KEY_EXT_W'(TABLE_DEPTH);
            r_is_add <= (i_req_type == REQ_ADD);
            r_amt    <= i_amount;
        end
        r_cmp_key <= r_cnt;
        if (i_cmd.best_clr) begin
            r_best     <= '0;
            r_best_key <= '0;
            r_found    <= 1'b0;
        end else if (take) begin
            r_best     <= rdata;
            r_best_key <= r_cmp_key;
            r_found    <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_key <= best_ext[KEY_W-1:0];
            r_out_vld <= r_found;
        end
    end

    assign best_ext       = KEY_EXT_W'(r_best_key);
    assign o_sts.is_query = (i_req_type != REQ_ADD) && (i_req_type != REQ_REMOVE);
    assign o_sts.cnt_last = (r_cnt == ADDR_W'(TABLE_DEPTH - 1));
    assign o_top_key      = r_out_key;
    assign o_top_valid    = r_out_vld;
endmodule

/* sv/frequency_table_max_query.sv */
// Frequency count table with a most-frequent-key query.
// i_req carries req_type, key and amount: add (saturating at the count maximum),
// remove (clamped at zero) or query. o_rsp carries top_key and top_valid, one item
// per query; add and remove give no result.
// Add and remove each go through accept, table read and table write.
// A query reads the whole table through the single read port of the count RAM,
// one entry per cycle, and registers the result in the output register; the
// block then returns to idle and takes the next item.
// Ties go to the larger key; an all-zero table gives top_valid 0 and top_key 0.
// After reset the block clears all TABLE_DEPTH (4096) entries, one per cycle,
// with i_req.ready low; results pending at reset are dropped.
// The result sits in an output register: while o_rsp is stalled the block keeps
// taking add and remove items, and a later query waits at its end until the
// earlier result has been taken.
module frequency_table_max_query (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ftmq_req_if.sink   i_req,
    ftmq_rsp_if.source o_rsp
);
    import ftmq_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;
    logic [KEY_W-1:0] top_key;
    logic top_valid;

    ftmq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ftmq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_type  (i_req.req_type),
        .i_key       (i_req.key),
        .i_amount    (i_req.amount),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_top_key   (top_key),
        .o_top_valid (top_valid)
    );

    assign i_req.ready     = in_ready;
    assign o_rsp.valid     = out_valid;
    assign o_rsp.top_key   = top_key;
    assign o_rsp.top_valid = top_valid;
endmodule

/* sv/ftmq_chk.sv */
`include "frequency_table_max_query_defines.svh"

module ftmq_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic [ftmq_pkg::KEY_W-1:0] i_top_key,
    input logic                       i_top_valid
);
    import ftmq_pkg::*;

    `FTMQ_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_top_key) && $stable(i_top_valid))
    `FTMQ_ASSERT_IMP(a_empty_key, i_clk, i_rst_n, i_rsp_valid && !i_top_valid, i_top_key == '0)
    `FTMQ_ASSERT_RST(a_rst_busy, i_clk, i_rst_n, !i_req_ready && !i_rsp_valid)
    `FTMQ_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)
    `FTMQ_ASSERT_IMP(a_rsp_from_scan, i_clk, i_rst_n, $rose(i_rsp_valid), $past(!i_req_ready))
endmodule

bind frequency_table_max_query ftmq_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_top_key   (o_rsp.top_key),
    .i_top_valid (o_rsp.top_valid)
);
